// ===== design/ilb_pkg.sv =====
package ilb_pkg;

  localparam int MODE_W    = 2;
  localparam int POS_W     = 6;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 6;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DN,
    S_READ,
    S_FINISH
  } state_t;

endpackage

// ===== design/ilb_if.sv =====
interface ilb_req_if;
  import ilb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output mode, output position, output data_in, input ready);
  modport sink   (input valid, input mode, input position, input data_in, output ready);
endinterface

interface ilb_rsp_if;
  import ilb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STAT_W-1:0]        status;
  logic [CNT_OUT_W-1:0]     count_out;

  modport source (output valid, output data_out, output status, output count_out, input ready);
  modport sink   (input valid, input data_out, input status, input count_out, output ready);
endinterface

// ===== design/ilb_ram.sv =====
module ilb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/indexed_list_buffer_top.sv =====
// Ordered list of up to CAPACITY signed words, addressed by position from 1,
// held in one dual-port memory with one read and one write port. Each request
// beat is an insert before a position, a delete, a get or a set, and gives
// exactly one response beat with the value read by get, a status and the
// element count after the operation. Items are processed one at a time. An
// insert at position p into a non-empty list moves the tail up one word per
// cycle and then writes the new word at p; a delete of any but the last word
// moves the words above it down one place. The response register lets a new
// request be accepted while the previous response still waits to be taken.
module indexed_list_buffer_top #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  ilb_req_if.sink   req,
  ilb_rsp_if.source rsp
);
  import ilb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     k, k_next;
  op_t               op;
  logic [AW-1:0]     pidx;
  logic [DATA_W-1:0] wval;
  status_t           stat;
  logic [DATA_W-1:0] rd, rd_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              accept;
  logic              out_free;
  logic [CW+5:0]     pos_e, cnt_e, pos_m1;
  logic              pos_ok;
  status_t           stat_in;
  logic [AW-1:0]     pidx_in;
  logic [CW-1:0]     count_m1;
  logic [CW:0]       k_ext, cnt_x;

  ilb_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  assign pos_e    = {{CW{1'b0}}, req.position};
  assign cnt_e    = {6'b0, count};
  assign pos_m1   = pos_e - 1'b1;
  assign pidx_in  = pos_m1[AW-1:0];
  assign count_m1 = count - 1'b1;
  assign k_ext    = {{(CW + 1 - AW){1'b0}}, k};
  assign cnt_x    = {1'b0, count};

  always_comb begin
    pos_ok = (pos_e != '0) &&
             ((pos_e <= cnt_e) || ((op_t'(req.mode) == OP_INSERT) && (pos_e == 1)));
    if (!pos_ok) begin
      stat_in = ST_BADPOS;
    end else if ((op_t'(req.mode) == OP_INSERT) && (count == CW'(CAPACITY))) begin
      stat_in = ST_FULL;
    end else begin
      stat_in = ST_OK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat_in != ST_OK) begin
            state_next = S_FINISH;
          end else begin
            unique case (op_t'(req.mode))
              OP_INSERT: state_next = (count == '0) ? S_FINISH : S_UP;
              OP_DELETE: state_next = ((pidx_in + 1'b1) == count_m1[AW-1:0] + 1'b1 &&
                                       pos_e == cnt_e) ? S_FINISH : S_DN;
              OP_GET:    state_next = S_READ;
              OP_SET:    state_next = S_FINISH;
              default:   state_next = S_FINISH;
            endcase
          end
        end
      end
      S_UP:     state_next = ((k - 1'b1) == pidx) ? S_PUT : S_UP;
      S_PUT:    state_next = S_FINISH;
      S_DN:     state_next = ((k_ext + 2'd2) == cnt_x) ? S_FINISH : S_DN;
      S_READ:   state_next = S_FINISH;
      S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = k;
    ram_wdata  = ram_rdata;
    ram_raddr  = k;
    count_next = count;
    k_next     = k;
    rd_next    = rd;
    unique case (state)
      S_IDLE: begin
        rd_next = '0;
        if (accept && (stat_in == ST_OK)) begin
          unique case (op_t'(req.mode))
            OP_INSERT: begin
              if (count == '0) begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = req.data_in;
                count_next = count + 1'b1;
              end else begin
                ram_raddr = count_m1[AW-1:0];
                k_next    = count[AW-1:0];
              end
            end
            OP_DELETE: begin
              if (pos_e == cnt_e) begin
                count_next = count_m1;
              end else begin
                ram_raddr = pidx_in + 1'b1;
                k_next    = pidx_in;
              end
            end
            OP_GET: begin
              ram_raddr = pidx_in;
            end
            OP_SET: begin
              ram_we    = 1'b1;
              ram_waddr = pidx_in;
              ram_wdata = req.data_in;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = k;
        ram_wdata = ram_rdata;
        ram_raddr = k - AW'(2);
        k_next    = k - 1'b1;
      end
      S_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = pidx;
        ram_wdata  = wval;
        count_next = count + 1'b1;
      end
      S_DN: begin
        ram_we    = 1'b1;
        ram_waddr = k;
        ram_wdata = ram_rdata;
        ram_raddr = k + AW'(2);
        k_next    = k + 1'b1;
        if ((k_ext + 2'd2) == cnt_x) begin
          count_next = count_m1;
        end
      end
      S_READ: begin
        rd_next = ram_rdata;
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if ((state == S_FINISH) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k  <= k_next;
    rd <= rd_next;
    if (accept) begin
      op   <= op_t'(req.mode);
      pidx <= pidx_in;
      wval <= req.data_in;
      stat <= stat_in;
    end
    if ((state == S_FINISH) && out_free) begin
      rsp.data_out  <= ((op == OP_GET) && (stat == ST_OK)) ? rd : '0;
      rsp.status    <= stat;
      rsp.count_out <= cnt_e[CNT_OUT_W-1:0];
    end
  end

endmodule
